// ===== hw/rtl/dcp_pkg.sv =====
// Package for the digest challenge parser: types, constants and helper functions.
package dcp_pkg;

  localparam int unsigned RealmCap  = 64;
  localparam int unsigned NonceCap  = 128;
  localparam int unsigned OpaqueCap = 128;
  localparam int unsigned AlgoCap   = 32;
  localparam int unsigned QopCap    = 32;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_SEP    = 3'd2,
    PH_KEY    = 3'd3,
    PH_VSTART = 3'd4,
    PH_QVAL   = 3'd5,
    PH_BVAL   = 3'd6
  } phase_t;

  localparam logic [2:0] TGT_REALM  = 3'd0;
  localparam logic [2:0] TGT_NONCE  = 3'd1;
  localparam logic [2:0] TGT_OPAQUE = 3'd2;
  localparam logic [2:0] TGT_ALGO   = 3'd3;
  localparam logic [2:0] TGT_QOP    = 3'd4;
  localparam logic [2:0] TGT_NONE   = 3'd7;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Parser state, carried between items.
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  prefix_count;
    logic [4:0]  key_bits;
    logic [3:0]  key_len;
    logic [2:0]  target;
    logic [6:0]  vidx;
    logic [63:0] qwin;
    logic [3:0]  qflags;
    logic [6:0]  len0;
    logic [6:0]  len1;
    logic [6:0]  len2;
    logic [6:0]  len3;
    logic        qop_state;
    logic        algo_given;
  } pstate_t;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [1:0] field_id;
    logic [6:0] char_index;
    logic [7:0] char_out;
    logic       challenge_valid;
    logic       qop_code;
    logic [5:0] realm_length;
    logic [6:0] nonce_length;
    logic [6:0] opaque_length;
    logic [4:0] algorithm_length;
    logic       algorithm_default;
    logic       last_result;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  function automatic pstate_t reset_state();
    pstate_t s;
    s = '0;
    s.phase    = PH_LEAD;
    s.key_bits = 5'h1F;
    s.target   = TGT_NONE;
    return s;
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] prefix_letter(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "d";
      3'd1: r = "i";
      3'd2: r = "g";
      3'd3: r = "e";
      3'd4: r = "s";
      3'd5: r = "t";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Letter k of candidate key i; zero beyond its length.
  function automatic logic [7:0] key_letter(input logic [2:0] i, input logic [3:0] k);
    logic [79:0] w;
    case (i)
      3'd0: w = {"realm", 40'h0};
      3'd1: w = {"nonce", 40'h0};
      3'd2: w = {"opaque", 32'h0};
      3'd3: w = {"qop", 56'h0};
      default: w = {"algorithm", 8'h0};
    endcase
    return (k < 4'd10) ? w[79 - 8*k -: 8] : 8'h00;
  endfunction

  function automatic logic [3:0] key_size(input logic [2:0] i);
    logic [3:0] r;
    case (i)
      3'd0: r = 4'd5;
      3'd1: r = 4'd5;
      3'd2: r = 4'd6;
      3'd3: r = 4'd3;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] key_target(input logic [2:0] i);
    logic [2:0] r;
    case (i)
      3'd0: r = TGT_REALM;
      3'd1: r = TGT_NONCE;
      3'd2: r = TGT_OPAQUE;
      3'd3: r = TGT_QOP;
      default: r = TGT_ALGO;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] field_cap(input logic [1:0] f);
    logic [8:0] r;
    case (f)
      2'd0: r = 9'(RealmCap);
      2'd1: r = 9'(NonceCap);
      2'd2: r = 9'(OpaqueCap);
      default: r = 9'(AlgoCap);
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/digest_challenge_parser.sv =====
// Top level of the digest challenge parser.
//
// The block takes a Digest authentication challenge header one character per
// input item on the in_ channel (in_tdata is the character, in_tlast marks the
// last one; a zero character also ends the header). Every kept character of
// realm, nonce, opaque or algorithm leaves on the out_ channel as a character
// item, and the end of the header adds a summary item with out_tlast high.
// out_tuser tells the two kinds apart.
// An accepted character is applied to the parser state in the same cycle and
// its results are written to a two-entry output queue, so the first result
// is offered in the cycle after acceptance. One item is taken every cycle while
// the queue drains and the receiver is ready; the queue only takes a new item
// when it is empty or this cycle's pop leaves it empty, so a final character
// that yields two results holds in_tready low until the queue drains. When the
// receiver stalls, results wait in the queue and in_tready falls. Reset
// (synchronous, active low) empties the queue and returns the parser to the
// start of a header; after each summary it does so by itself.
module digest_challenge_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_in
  input  logic        in_tlast,   // final_req
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] field_id, [8:2] char_index, [16:9] char_out, [17] challenge_valid,
  // [18] qop_code, [24:19] realm_length, [31:25] nonce_length,
  // [38:32] opaque_length, [43:39] algorithm_length, [44] algorithm_default,
  // [47:45] zero fill
  output logic [47:0] out_tdata,
  output logic        out_tuser,  // kind
  output logic        out_tlast   // last_result
);

  dcp_pkg::pstate_t st_r, st_nxt;
  dcp_pkg::result_t char_res, sum_res, q_data;
  logic             char_vld, sum_vld, room, acc;

  assign in_tready = room;
  assign acc = in_tvalid && in_tready;

  dcp_step u_step (
    .st      (st_r),
    .c       (in_tdata),
    .fin     (in_tlast),
    .st_nxt  (st_nxt),
    .char_vld(char_vld),
    .char_res(char_res),
    .sum_vld (sum_vld),
    .sum_res (sum_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= dcp_pkg::reset_state();
    else if (acc) st_r <= st_nxt;
  end

  dcp_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_a   (acc && char_vld),
    .data_a   (char_res),
    .push_b   (acc && sum_vld),
    .data_b   (sum_res),
    .has_room2(room),
    .out_vld  (out_tvalid),
    .out_data (q_data),
    .out_rdy  (out_tready)
  );

  assign out_tuser = q_data.kind;
  assign out_tlast = q_data.last_result;
  assign out_tdata = {3'b000, q_data.algorithm_default, q_data.algorithm_length,
                      q_data.opaque_length, q_data.nonce_length, q_data.realm_length,
                      q_data.qop_code, q_data.challenge_valid, q_data.char_out,
                      q_data.char_index, q_data.field_id};

  // A summary always carries last set and kind summary.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == out_tuser)) else $error("last/kind mismatch");
  // Parser state returns to header start after an accepted end of header.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tlast || in_tdata == 8'h00)) |=>
      st_r.phase == dcp_pkg::PH_LEAD) else $error("no restart after header end");
  // A result that the receiver stalls while in_tready is low stays offered in the next cycle.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && !in_tready) |=> out_tvalid) else $error("result lost");

endmodule

// ===== hw/rtl/dcp_step.sv =====
// Combinational step logic: one character applied to the parser state.
module dcp_step (
  input  dcp_pkg::pstate_t st,
  input  logic [7:0]       c,
  input  logic             fin,
  output dcp_pkg::pstate_t st_nxt,
  output logic             char_vld,
  output dcp_pkg::result_t char_res,
  output logic             sum_vld,
  output dcp_pkg::result_t sum_res
);

  always_comb begin
    dcp_pkg::pstate_t s;
    logic again;
    logic [7:0] lc;
    logic [8:0] cap;
    logic [2:0] tg;
    logic [63:0] w;
    logic [1:0] fid;
    logic [6:0] l3;
    s = st;
    char_vld = 1'b0;
    char_res = '0;
    sum_res = '0;
    lc = dcp_pkg::lower_ascii(c);
    cap = '0;
    tg = '0;
    w = '0;
    fid = '0;
    l3 = '0;
    sum_vld = (c == 8'h00) || fin;
    // At most four phase transitions chain on one character.
    again = (c != 8'h00);
    for (int pass = 0; pass < 4; pass++) begin
      if (again) begin
        again = 1'b0;
        case (s.phase)
          dcp_pkg::PH_LEAD: begin
            if (c != dcp_pkg::CH_SPACE) begin
              s.phase = dcp_pkg::PH_PREFIX;
              s.prefix_count = '0;
              again = 1'b1;
            end
          end
          dcp_pkg::PH_PREFIX: begin
            if (s.prefix_count < 3'd6 && lc == dcp_pkg::prefix_letter(s.prefix_count)) begin
              s.prefix_count = s.prefix_count + 3'd1;
              if (s.prefix_count >= 3'd6) s.phase = dcp_pkg::PH_SEP;
            end else if (s.prefix_count == 3'd0) begin
              s.phase = dcp_pkg::PH_SEP;
              again = 1'b1;
            end else begin
              s.phase = dcp_pkg::PH_KEY;
              s.key_len = {1'b0, s.prefix_count};
              s.key_bits = '0;
              again = 1'b1;
            end
          end
          dcp_pkg::PH_SEP: begin
            if (!(c == dcp_pkg::CH_SPACE || c == dcp_pkg::CH_COMMA || c == dcp_pkg::CH_TAB)) begin
              s.key_len = '0;
              s.key_bits = 5'h1F;
              s.phase = dcp_pkg::PH_KEY;
              again = 1'b1;
            end
          end
          dcp_pkg::PH_KEY: begin
            if (c == dcp_pkg::CH_EQ) begin
              tg = dcp_pkg::TGT_NONE;
              for (int i = 0; i < 5; i++) begin
                if (s.key_bits[i] && s.key_len == dcp_pkg::key_size(3'(i)))
                  tg = dcp_pkg::key_target(3'(i));
              end
              s.target = tg;
              s.vidx = '0;
              case (tg)
                dcp_pkg::TGT_REALM: s.len0 = '0;
                dcp_pkg::TGT_NONCE: s.len1 = '0;
                dcp_pkg::TGT_OPAQUE: s.len2 = '0;
                dcp_pkg::TGT_ALGO: begin
                  s.len3 = '0;
                  s.algo_given = 1'b1;
                end
                dcp_pkg::TGT_QOP: begin
                  s.qwin = '0;
                  s.qflags = '0;
                end
                default: ;
              endcase
              s.phase = dcp_pkg::PH_VSTART;
            end else if (c == dcp_pkg::CH_COMMA) begin
              s.phase = dcp_pkg::PH_SEP;
            end else begin
              for (int i = 0; i < 5; i++) begin
                if (s.key_bits[i] && !(s.key_len < dcp_pkg::key_size(3'(i)) &&
                    lc == dcp_pkg::key_letter(3'(i), s.key_len)))
                  s.key_bits[i] = 1'b0;
              end
              if (s.key_len < 4'd15) s.key_len = s.key_len + 4'd1;
            end
          end
          dcp_pkg::PH_VSTART: begin
            if (c == dcp_pkg::CH_QUOTE) begin
              s.phase = dcp_pkg::PH_QVAL;
            end else begin
              s.phase = dcp_pkg::PH_BVAL;
              again = 1'b1;
            end
          end
          default: begin
            // Quoted or bare value.
            if ((s.phase == dcp_pkg::PH_QVAL && c == dcp_pkg::CH_QUOTE) ||
                (s.phase == dcp_pkg::PH_BVAL && (c == dcp_pkg::CH_COMMA ||
                 c == dcp_pkg::CH_SPACE || c == dcp_pkg::CH_CR || c == dcp_pkg::CH_LF))) begin
              if (s.target == dcp_pkg::TGT_QOP) begin
                if (s.qflags[1] && !s.qflags[2] && !s.qflags[3]) s.qop_state = 1'b0;
                else if (s.qflags[0]) s.qop_state = 1'b1;
              end
              s.target = dcp_pkg::TGT_NONE;
              again = (s.phase == dcp_pkg::PH_BVAL);
              s.phase = dcp_pkg::PH_SEP;
            end else if (s.phase != dcp_pkg::PH_QVAL && s.phase != dcp_pkg::PH_BVAL) begin
              s.phase = dcp_pkg::PH_SEP;
              again = 1'b1;
            end else if (s.target < 3'd4) begin
              fid = s.target[1:0];
              cap = dcp_pkg::field_cap(fid);
              if ({2'b0, s.vidx} < cap - 9'd1) begin
                char_vld = 1'b1;
                char_res.kind = dcp_pkg::KIND_CHAR;
                char_res.field_id = fid;
                char_res.char_index = s.vidx;
                char_res.char_out = c;
                s.vidx = s.vidx + 7'd1;
                case (fid)
                  2'd0: s.len0 = s.vidx;
                  2'd1: s.len1 = s.vidx;
                  2'd2: s.len2 = s.vidx;
                  default: s.len3 = s.vidx;
                endcase
              end
            end else if (s.target == dcp_pkg::TGT_QOP) begin
              if ({2'b0, s.vidx} < 9'(dcp_pkg::QopCap) - 9'd1) begin
                w = {s.qwin[55:0], c};
                s.qwin = w;
                if (w[31:0] == "auth") s.qflags[0] = 1'b1;
                if (w == "auth-int") s.qflags[1] = 1'b1;
                if (w[39:0] == "auth,") s.qflags[2] = 1'b1;
                if (w[39:0] == "auth ") s.qflags[3] = 1'b1;
                s.vidx = s.vidx + 7'd1;
              end
            end
          end
        endcase
      end
    end
    if (sum_vld) begin
      if ((s.phase == dcp_pkg::PH_VSTART || s.phase == dcp_pkg::PH_QVAL ||
           s.phase == dcp_pkg::PH_BVAL) && s.target == dcp_pkg::TGT_QOP) begin
        if (s.qflags[1] && !s.qflags[2] && !s.qflags[3]) s.qop_state = 1'b0;
        else if (s.qflags[0]) s.qop_state = 1'b1;
      end
      l3 = s.algo_given ? s.len3 : 7'd3;
      sum_res.kind = dcp_pkg::KIND_SUMMARY;
      sum_res.challenge_valid = (s.len0 != '0) && (s.len1 != '0);
      sum_res.qop_code = s.qop_state;
      sum_res.realm_length = s.len0[5:0];
      sum_res.nonce_length = s.len1;
      sum_res.opaque_length = s.len2;
      sum_res.algorithm_length = l3[4:0];
      sum_res.algorithm_default = !s.algo_given;
      sum_res.last_result = 1'b1;
      s = dcp_pkg::reset_state();
    end
    st_nxt = s;
  end

endmodule

// ===== hw/rtl/dcp_out_queue.sv =====
// Two-entry result queue that decouples the parser from the output receiver.
module dcp_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_a,
  input  dcp_pkg::result_t data_a,
  input  logic             push_b,
  input  dcp_pkg::result_t data_b,
  output logic             has_room2,
  output logic             out_vld,
  output dcp_pkg::result_t out_data,
  input  logic             out_rdy
);

  dcp_pkg::result_t mem_r [2];
  logic             rd_r, rd_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;
  logic [1:0]       npush;
  logic             wa, wb;

  assign pop = out_vld && out_rdy;
  assign npush = {1'b0, push_a} + {1'b0, push_b};
  assign out_vld = cnt_r != 2'd0;
  assign out_data = mem_r[rd_r];
  // Room for two after this cycle's pop: accept only when the queue will be empty.
  assign has_room2 = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign cnt_nxt = cnt_r + npush - {1'b0, pop};
  assign rd_nxt = rd_r ^ pop;
  assign wa = rd_r ^ cnt_r[0];
  assign wb = ~wa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) mem_r[wa] <= data_a;
    if (push_b) mem_r[push_a ? wb : wa] <= data_b;
  end

endmodule
